// ===== rtl/stecho_pkg.sv =====
// Shared constants, register codes and helpers for the single-tap echo unit.
// Depends on nothing; used by single_tap_echo_with_mix_unit.
package stecho_pkg;

    localparam int MAX_DELAY    = 4096;
    localparam int ADDR_W       = $clog2(MAX_DELAY);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SAMPLE_W     = 16;
    localparam int DELAY_W      = 13;
    localparam int MIX_W        = 7;
    localparam int PERCENT_FULL = 100;
    localparam int PIPE_STAGES  = 6;

    // Reset values of the two configuration registers.
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(4000);
    localparam logic [MIX_W-1:0]   MIX_RESET   = MIX_W'(100);

    // A decay of 60/100 equals 3/5 exactly, so the echo tap is past*3 then a
    // truncating divide by five. Both divides use a rounded-up reciprocal whose
    // error stays below the smallest fractional step over the operand range.
    localparam int DIV5_SHIFT   = 19;
    localparam logic [16:0] DIV5_MUL   = 17'((2 ** DIV5_SHIFT) / 5 + 1);
    localparam int DIV100_SHIFT = 29;
    localparam logic [22:0] DIV100_MUL = 23'((2 ** DIV100_SHIFT) / PERCENT_FULL + 1);

    typedef enum logic [0:0] {
        REG_DELAY_LENGTH = 1'b0,
        REG_WET_PERCENT  = 1'b1
    } reg_idx_t;

    // Clamp a 17-bit signed value into the 16-bit sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 17'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -17'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/single_tap_echo_with_mix_unit.sv =====
// Single-tap feedforward echo with dry/wet mix, one audio sample per request.
// Depends on stecho_pkg for constants, register codes and saturation.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  request  | req_valid, req_stall | sample_in, last_in_buffer
//  result   | rsp_valid, rsp_stall | sample_out
//  config   | APB psel/penable     | paddr, pwdata, prdata
//
// The unit accepts one request per clock while no result is held, and passes
// it through the pipeline stages to the output register; throughput is set by
// the history memory, which takes one write and one read in the accept cycle.
// Reset clears the write position, the sample count, the pipeline valid bits
// and loads the register defaults; the history memory is not cleared.
// A stalled result freezes the whole pipeline and stalls the request side.
module single_tap_echo_with_mix_unit (
    input  logic                clk,
    input  logic                rst_n,
    // Request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  logic signed [15:0]  sample_in,
    input  logic                last_in_buffer,
    // Result channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic signed [15:0]  sample_out,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Values are stored raw and clamped at use.
    // ------------------------------------------------------------------
    logic [stecho_pkg::DELAY_W-1:0] delay_reg;
    logic [stecho_pkg::MIX_W-1:0]   mix_reg;
    stecho_pkg::reg_idx_t           reg_sel;
    logic                           cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = stecho_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= stecho_pkg::DELAY_RESET;
            mix_reg   <= stecho_pkg::MIX_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                stecho_pkg::REG_DELAY_LENGTH: delay_reg <= pwdata[stecho_pkg::DELAY_W-1:0];
                stecho_pkg::REG_WET_PERCENT:  mix_reg   <= pwdata[stecho_pkg::MIX_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            stecho_pkg::REG_DELAY_LENGTH: prdata = {19'b0, delay_reg};
            stecho_pkg::REG_WET_PERCENT:  prdata = {25'b0, mix_reg};
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. Every stage moves together; a result held by the
    // consumer stops all of them and the request side with them.
    // ------------------------------------------------------------------
    logic                                adv;
    logic                                fire;
    logic [stecho_pkg::PIPE_STAGES-1:0]  vld_reg;
    logic [stecho_pkg::PIPE_STAGES-1:0]  vld_next;
    logic                                rsp_valid_reg;
    logic                                rsp_valid_next;

    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;
    assign fire      = req_valid && adv;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        vld_next       = vld_reg;
        rsp_valid_next = rsp_valid_reg;
        if (adv)
        begin
            vld_next       = {vld_reg[stecho_pkg::PIPE_STAGES-2:0], fire};
            rsp_valid_next = vld_reg[stecho_pkg::PIPE_STAGES-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // History ring and buffer position. The sample is written and the delayed
    // sample is read in the same accept cycle; the read sees the old contents,
    // so a delay of the full ring length returns the entry being replaced and
    // a delay of one returns the previous request's sample, already written.
    // ------------------------------------------------------------------
    logic [stecho_pkg::ADDR_W-1:0]  wp_reg;
    logic [stecho_pkg::ADDR_W-1:0]  wp_next;
    logic [stecho_pkg::CNT_W-1:0]   seen_reg;
    logic [stecho_pkg::CNT_W-1:0]   seen_next;
    logic [stecho_pkg::DELAY_W-1:0] delay_eff;
    logic [stecho_pkg::MIX_W-1:0]   mix_eff;
    logic                           echo_on;
    logic [stecho_pkg::ADDR_W-1:0]  rp;
    logic                           rd_en;

    logic [stecho_pkg::SAMPLE_W-1:0] hist_mem [stecho_pkg::MAX_DELAY];
    logic signed [15:0]              rdata_reg;

    always_comb
    begin
        delay_eff = (delay_reg > stecho_pkg::DELAY_W'(stecho_pkg::MAX_DELAY))
                  ? stecho_pkg::DELAY_W'(stecho_pkg::MAX_DELAY) : delay_reg;
        mix_eff   = (mix_reg > stecho_pkg::MIX_W'(stecho_pkg::PERCENT_FULL))
                  ? stecho_pkg::MIX_W'(stecho_pkg::PERCENT_FULL) : mix_reg;
        // The echo starts once this buffer has seen at least the delay.
        echo_on   = (delay_eff != '0) && (seen_reg >= delay_eff);
        rp        = wp_reg - delay_eff[stecho_pkg::ADDR_W-1:0];
        rd_en     = fire && echo_on;
        wp_next   = wp_reg + stecho_pkg::ADDR_W'(1);
        if (last_in_buffer)
        begin
            seen_next = '0;
        end
        else if (seen_reg < stecho_pkg::CNT_W'(stecho_pkg::MAX_DELAY))
        begin
            seen_next = seen_reg + stecho_pkg::CNT_W'(1);
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            seen_reg <= '0;
        end
        else if (fire)
        begin
            wp_reg   <= wp_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hist_mem[wp_reg] <= sample_in;
        end
        if (rd_en)
        begin
            rdata_reg <= hist_mem[rp];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: request captured, delayed sample arriving from memory.
    // ------------------------------------------------------------------
    logic signed [15:0]             s1_dry_reg;
    logic                           s1_echo_reg;
    logic [stecho_pkg::MIX_W-1:0]   s1_mix_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_dry_reg  <= sample_in;
            s1_echo_reg <= echo_on;
            s1_mix_reg  <= mix_eff;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude and sign of past*3.
    // ------------------------------------------------------------------
    logic signed [17:0]             p3;
    logic [17:0]                    p3_neg;
    logic [16:0]                    s2_mag_next;
    logic signed [15:0]             s2_dry_reg;
    logic                           s2_echo_reg;
    logic [stecho_pkg::MIX_W-1:0]   s2_mix_reg;
    logic [16:0]                    s2_mag_reg;
    logic                           s2_neg_reg;

    always_comb
    begin
        p3          = {{2{rdata_reg[15]}}, rdata_reg} + {rdata_reg[15], rdata_reg, 1'b0};
        p3_neg      = -p3;
        s2_mag_next = p3[17] ? p3_neg[16:0] : p3[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_dry_reg  <= s1_dry_reg;
            s2_echo_reg <= s1_echo_reg;
            s2_mix_reg  <= s1_mix_reg;
            s2_mag_reg  <= s2_mag_next;
            s2_neg_reg  <= p3[17];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: truncating divide by five through the reciprocal.
    // ------------------------------------------------------------------
    logic [33:0]                    div5_prod;
    logic signed [15:0]             s3_dry_reg;
    logic                           s3_echo_reg;
    logic [stecho_pkg::MIX_W-1:0]   s3_mix_reg;
    logic [14:0]                    s3_q_reg;
    logic                           s3_neg_reg;

    assign div5_prod = {17'b0, s2_mag_reg} * {17'b0, stecho_pkg::DIV5_MUL};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_dry_reg  <= s2_dry_reg;
            s3_echo_reg <= s2_echo_reg;
            s3_mix_reg  <= s2_mix_reg;
            s3_q_reg    <= div5_prod[stecho_pkg::DIV5_SHIFT+14:stecho_pkg::DIV5_SHIFT];
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: wet value, saturated; the dry sample where no echo applies.
    // ------------------------------------------------------------------
    logic signed [16:0]             tap;
    logic signed [16:0]             wet_sum;
    logic signed [15:0]             s4_wet_next;
    logic signed [15:0]             s4_dry_reg;
    logic signed [15:0]             s4_wet_reg;
    logic [stecho_pkg::MIX_W-1:0]   s4_mix_reg;

    always_comb
    begin
        tap         = s3_neg_reg ? -{2'b0, s3_q_reg} : {2'b0, s3_q_reg};
        wet_sum     = {s3_dry_reg[15], s3_dry_reg} + tap;
        s4_wet_next = s3_echo_reg ? stecho_pkg::sat16(wet_sum) : s3_dry_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_dry_reg <= s3_dry_reg;
            s4_wet_reg <= s4_wet_next;
            s4_mix_reg <= s3_mix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: dry*(100-mix) + wet*mix, rewritten as dry*100 + (wet-dry)*mix.
    // ------------------------------------------------------------------
    logic signed [23:0]             dry_w;
    logic signed [23:0]             diff_w;
    logic signed [23:0]             mix_w;
    logic signed [23:0]             mix_sum;
    logic [23:0]                    mix_sum_neg;
    logic [21:0]                    s5_mag_reg;
    logic                           s5_neg_reg;

    always_comb
    begin
        dry_w       = {{8{s4_dry_reg[15]}}, s4_dry_reg};
        diff_w      = {{8{s4_wet_reg[15]}}, s4_wet_reg} - dry_w;
        mix_w       = {17'b0, s4_mix_reg};
        mix_sum     = (dry_w <<< 6) + (dry_w <<< 5) + (dry_w <<< 2) + diff_w * mix_w;
        mix_sum_neg = -mix_sum;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_mag_reg <= mix_sum[23] ? mix_sum_neg[21:0] : mix_sum[21:0];
            s5_neg_reg <= mix_sum[23];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: truncating divide by one hundred through the reciprocal.
    // ------------------------------------------------------------------
    logic [44:0]                    div100_prod;
    logic [15:0]                    s6_q_reg;
    logic                           s6_neg_reg;

    assign div100_prod = {23'b0, s5_mag_reg} * {22'b0, stecho_pkg::DIV100_MUL};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_q_reg   <= div100_prod[stecho_pkg::DIV100_SHIFT+15:stecho_pkg::DIV100_SHIFT];
            s6_neg_reg <= s5_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: restore the sign and saturate.
    // ------------------------------------------------------------------
    logic signed [16:0]             out_wide;
    logic signed [15:0]             out_reg;

    assign out_wide = s6_neg_reg ? -{1'b0, s6_q_reg} : {1'b0, s6_q_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= stecho_pkg::sat16(out_wide);
        end
    end

    assign sample_out = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= stecho_pkg::CNT_W'(stecho_pkg::MAX_DELAY))
        else $error("sample count above ring depth");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_in_buffer |=> seen_reg == '0)
        else $error("end of buffer did not clear the sample count");

    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> wp_reg == stecho_pkg::ADDR_W'($past(wp_reg) + 1))
        else $error("write position did not advance by one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(vld_reg) && $stable(wp_reg))
        else $error("pipeline moved while the result was held");

    a_read_needs_echo: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> delay_eff != '0 && seen_reg >= delay_eff)
        else $error("history read before the delay was reached");

endmodule
